/* rtl/ca3d_pkg.sv */
// Shared types, codes and constants of the 3D cellular automaton step unit.
package ca3d_pkg;

    localparam int GRID_SIDE_DEF = 16;
    localparam int MASK_W        = 27;
    localparam int STATE_W       = 5;
    localparam int COUNT_W       = 5;
    localparam int COORD_W       = 4;
    localparam int SCOUNT_W      = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 27;

    localparam logic [MASK_W-1:0]   SURVIVE_RST     = 27'd2;
    localparam logic [MASK_W-1:0]   BORN_RST        = 27'd10;
    localparam logic [SCOUNT_W-1:0] STATE_COUNT_RST = 6'd2;
    localparam logic                NEIGHBOR_RST    = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RECOUNT = 2'd2,
        ACT_STEP    = 2'd3
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SURVIVE      = 2'd0,
        REG_BORN         = 2'd1,
        REG_STATE_COUNT  = 2'd2,
        REG_NEIGHBORHOOD = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_WRITE   = 3'd2,
        OP_READ    = 3'd3,
        OP_COMPUTE = 3'd4,
        OP_RECOUNT = 3'd5
    } op_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic [STATE_W-1:0] cell_value;
    } req_t;

    typedef struct packed {
        logic [STATE_W-1:0] cell_state;
        logic [COUNT_W-1:0] neighbor_total;
        logic [1:0]         action_done;
    } rsp_t;

    typedef struct packed {
        logic [MASK_W-1:0]  survive;
        logic [MASK_W-1:0]  born;
        logic [STATE_W-1:0] top;
        logic               von_neumann;
    } cfg_t;

    typedef struct packed {
        op_t  op;
        logic run;
        logic src_next;
        logic load_item;
        logic capture;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sweep_done;
    } stat_t;

endpackage

/* rtl/ca3d_ctrl.sv */
// Controller state machine that sequences the actions of the step unit.
module ca3d_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_action,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  ca3d_pkg::stat_t stat,
    output ca3d_pkg::cmd_t  cmd
);
    import ca3d_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_WRITE     = 9'b000000100,
        S_READ      = 9'b000001000,
        S_READ_WAIT = 9'b000010000,
        S_COMPUTE   = 9'b000100000,
        S_GAP       = 9'b001000000,
        S_COUNT     = 9'b010000000,
        S_FIN       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   step_reg, step_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.op         = OP_IDLE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op  = OP_CLEAR;
                cmd.run = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    step_next     = (req_action == ACT_STEP);
                    case (req_action)
                        ACT_WRITE:   state_next = S_WRITE;
                        ACT_READ:    state_next = S_READ;
                        ACT_RECOUNT: state_next = S_COUNT;
                        default:     state_next = S_COMPUTE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.op     = OP_WRITE;
                state_next = S_FIN;
            end
            S_READ:
            begin
                cmd.op     = OP_READ;
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                cmd.op      = OP_READ;
                cmd.capture = 1'b1;
                state_next  = S_FIN;
            end
            S_COMPUTE:
            begin
                cmd.op  = OP_COMPUTE;
                cmd.run = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.op       = OP_RECOUNT;
                cmd.run      = 1'b1;
                cmd.src_next = step_reg;
                if (stat.sweep_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/ca3d_datapath.sv */
// Datapath with the cell memories, sweep counters, next-state rule and neighbor counter.
module ca3d_datapath #(
    parameter int GRID_SIDE = ca3d_pkg::GRID_SIDE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ca3d_pkg::cfg_t  cfg,
    input  ca3d_pkg::cmd_t  cmd,
    input  ca3d_pkg::req_t  req,
    output ca3d_pkg::stat_t stat,
    output ca3d_pkg::rsp_t  rsp
);
    import ca3d_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int PLANE = GRID_SIDE * GRID_SIDE;

    function automatic logic [CW-1:0] wrap_in(input logic [COORD_W-1:0] v);
        logic [6:0] t;
        t = 7'(v);
        for (int i = 0; i < 5; i++)
        begin
            if (t >= 7'(GRID_SIDE))
            begin
                t = t - 7'(GRID_SIDE);
            end
        end
        return CW'(t);
    endfunction

    function automatic logic [CW-1:0] nbr(input logic [CW-1:0] c, input logic [1:0] d);
        logic [CW-1:0] r;
        case (d)
            2'd0:    r = (c == '0) ? CW'(GRID_SIDE - 1) : c - CW'(1);
            2'd2:    r = (c == CW'(GRID_SIDE - 1)) ? '0 : c + CW'(1);
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                           input logic [CW-1:0] z);
        return AW'(x) * AW'(PLANE) + AW'(y) * AW'(GRID_SIDE) + AW'(z);
    endfunction

    logic [STATE_W-1:0] st_mem  [CELLS];
    logic [COUNT_W-1:0] cnt_mem [CELLS];
    logic [STATE_W-1:0] nx_mem  [CELLS];

    req_t               item_reg;
    logic [CW-1:0]      cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic [1:0]         dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic               issued_all_reg, issued_all_next;
    logic               p_valid_reg;
    logic [AW-1:0]      p_addr_reg;
    logic               p_first_reg, p_last_reg, p_counted_reg, p_center_reg, p_done_reg;
    logic [COUNT_W-1:0] acc_reg;
    logic [STATE_W-1:0] center_reg;
    logic [STATE_W-1:0] st_rd_reg, nx_rd_reg, res_state_reg;
    logic [COUNT_W-1:0] cnt_rd_reg, res_count_reg;
    rsp_t               rsp_reg;

    logic               recount_mode, issue, cell_last, off_last, issue_last;
    logic [AW-1:0]      item_addr, cell_addr, nbr_addr, raddr;
    logic [1:0]         ne;
    logic               counted, first_off, center_off;
    logic [STATE_W-1:0] src, nx_val, clamp_val;
    logic               hit, born_bit, surv_bit;
    logic [COUNT_W-1:0] acc_sum;
    logic [31:0]        born_wide, surv_wide;
    logic               st_we, cnt_we, nx_we;
    logic [AW-1:0]      st_waddr, cnt_waddr;
    logic [STATE_W-1:0] st_wdata;
    logic [COUNT_W-1:0] cnt_wdata;

    assign recount_mode = (cmd.op == OP_RECOUNT);
    assign issue        = cmd.run & ~issued_all_reg;
    assign cell_last    = (cx_reg == CW'(GRID_SIDE - 1)) && (cy_reg == CW'(GRID_SIDE - 1))
                          && (cz_reg == CW'(GRID_SIDE - 1));
    assign off_last     = (dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2);
    assign issue_last   = cell_last && (!recount_mode || off_last);

    assign item_addr = addr(wrap_in(item_reg.cell_x), wrap_in(item_reg.cell_y),
                            wrap_in(item_reg.cell_z));
    assign cell_addr = addr(cx_reg, cy_reg, cz_reg);
    assign nbr_addr  = addr(nbr(cx_reg, dx_reg), nbr(cy_reg, dy_reg), nbr(cz_reg, dz_reg));
    assign raddr     = (cmd.op == OP_READ) ? item_addr : (recount_mode ? nbr_addr : cell_addr);

    assign ne = 2'(dx_reg != 2'd1) + 2'(dy_reg != 2'd1) + 2'(dz_reg != 2'd1);
    assign counted    = cfg.von_neumann ? (ne == 2'd1) : (ne != 2'd0);
    assign first_off  = (dx_reg == 2'd0) && (dy_reg == 2'd0) && (dz_reg == 2'd0);
    assign center_off = (dx_reg == 2'd1) && (dy_reg == 2'd1) && (dz_reg == 2'd1);

    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        dz_next = dz_reg;
        if (!cmd.run)
        begin
            cx_next = '0;
            cy_next = '0;
            cz_next = '0;
            dx_next = '0;
            dy_next = '0;
            dz_next = '0;
        end
        else if (issue)
        begin
            if (recount_mode)
            begin
                dz_next = (dz_reg == 2'd2) ? 2'd0 : dz_reg + 2'd1;
                if (dz_reg == 2'd2)
                begin
                    dy_next = (dy_reg == 2'd2) ? 2'd0 : dy_reg + 2'd1;
                    if (dy_reg == 2'd2)
                    begin
                        dx_next = (dx_reg == 2'd2) ? 2'd0 : dx_reg + 2'd1;
                    end
                end
            end
            if (!recount_mode || off_last)
            begin
                cz_next = (cz_reg == CW'(GRID_SIDE - 1)) ? '0 : cz_reg + CW'(1);
                if (cz_reg == CW'(GRID_SIDE - 1))
                begin
                    cy_next = (cy_reg == CW'(GRID_SIDE - 1)) ? '0 : cy_reg + CW'(1);
                    if (cy_reg == CW'(GRID_SIDE - 1))
                    begin
                        cx_next = (cx_reg == CW'(GRID_SIDE - 1)) ? '0 : cx_reg + CW'(1);
                    end
                end
            end
        end
    end

    assign issued_all_next = cmd.run & (issued_all_reg | (issue & issue_last));

    assign src       = cmd.src_next ? nx_rd_reg : st_rd_reg;
    assign hit       = p_counted_reg && (src == cfg.top);
    assign acc_sum   = (p_first_reg ? '0 : acc_reg) + COUNT_W'(hit);
    assign born_wide = 32'(cfg.born);
    assign surv_wide = 32'(cfg.survive);
    assign born_bit  = born_wide[cnt_rd_reg];
    assign surv_bit  = surv_wide[cnt_rd_reg];
    assign clamp_val = (item_reg.cell_value > cfg.top) ? cfg.top : item_reg.cell_value;

    always_comb
    begin
        if (st_rd_reg == '0)
        begin
            nx_val = born_bit ? cfg.top : '0;
        end
        else if (st_rd_reg == cfg.top)
        begin
            nx_val = surv_bit ? st_rd_reg : st_rd_reg - STATE_W'(1);
        end
        else
        begin
            nx_val = st_rd_reg - STATE_W'(1);
        end
    end

    always_comb
    begin
        st_we     = 1'b0;
        st_waddr  = p_addr_reg;
        st_wdata  = '0;
        cnt_we    = 1'b0;
        cnt_waddr = p_addr_reg;
        cnt_wdata = '0;
        nx_we     = 1'b0;
        case (cmd.op)
            OP_CLEAR:
            begin
                st_we  = p_valid_reg;
                cnt_we = p_valid_reg;
            end
            OP_WRITE:
            begin
                st_we    = 1'b1;
                st_waddr = item_addr;
                st_wdata = clamp_val;
            end
            OP_COMPUTE:
            begin
                nx_we = p_valid_reg;
            end
            OP_RECOUNT:
            begin
                cnt_we    = p_valid_reg & p_last_reg;
                cnt_wdata = acc_sum;
                st_we     = p_valid_reg & p_last_reg & cmd.src_next;
                st_wdata  = center_reg;
            end
            default:
            begin
                st_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rd_reg <= st_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            nx_mem[p_addr_reg] <= nx_val;
        end
        nx_rd_reg <= nx_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg         <= '0;
            cy_reg         <= '0;
            cz_reg         <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            dz_reg         <= '0;
            issued_all_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
        end
        else
        begin
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            cz_reg         <= cz_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            dz_reg         <= dz_next;
            issued_all_reg <= issued_all_next;
            p_valid_reg    <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg    <= cell_addr;
        p_first_reg   <= first_off;
        p_last_reg    <= !recount_mode || off_last;
        p_counted_reg <= counted;
        p_center_reg  <= center_off;
        p_done_reg    <= issue_last;
        if (p_valid_reg && recount_mode)
        begin
            acc_reg <= acc_sum;
        end
        if (p_valid_reg && p_center_reg)
        begin
            center_reg <= src;
        end
        if (cmd.load_item)
        begin
            item_reg      <= req;
            res_state_reg <= '0;
            res_count_reg <= '0;
        end
        else if (cmd.capture)
        begin
            res_state_reg <= st_rd_reg;
            res_count_reg <= cnt_rd_reg;
        end
        if (cmd.load_out)
        begin
            rsp_reg.cell_state     <= res_state_reg;
            rsp_reg.neighbor_total <= res_count_reg;
            rsp_reg.action_done    <= item_reg.action;
        end
    end

    assign stat.sweep_done = p_valid_reg & p_done_reg;
    assign rsp             = rsp_reg;

endmodule

/* rtl/cellular_automaton_3d_step_unit.sv */
// Top level of the 3D cellular automaton step unit with its configuration registers.
// The unit holds a toroidal cube of GRID_SIDE^3 cells in on-chip memories with one read
// address per cycle. After reset it clears the grid before it takes a word. A recount reads
// the 27 neighborhood positions of each cell one per cycle through the shared read address;
// a step adds a next-state pass before it. One word is worked on at a time, and a finished
// result waits in an output register while the next word is taken; a word that finishes
// while that register is still full waits in its last cycle.
module cellular_automaton_3d_step_unit #(
    parameter int GRID_SIDE = ca3d_pkg::GRID_SIDE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  ca3d_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output ca3d_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ca3d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ca3d_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ca3d_pkg::*;

    logic [MASK_W-1:0]   survive_reg;
    logic [MASK_W-1:0]   born_reg;
    logic [SCOUNT_W-1:0] state_count_reg;
    logic                neighbor_reg;
    logic [STATE_W-1:0]  top;
    cfg_t                cfg;
    cmd_t                cmd;
    stat_t               stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_reg     <= SURVIVE_RST;
            born_reg        <= BORN_RST;
            state_count_reg <= STATE_COUNT_RST;
            neighbor_reg    <= NEIGHBOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SURVIVE:      survive_reg     <= cfg_data;
                REG_BORN:         born_reg        <= cfg_data;
                REG_STATE_COUNT:  state_count_reg <= cfg_data[SCOUNT_W-1:0];
                REG_NEIGHBORHOOD: neighbor_reg    <= cfg_data[0];
                default:          neighbor_reg    <= neighbor_reg;
            endcase
        end
    end

    always_comb
    begin
        if (state_count_reg < 6'd2)
        begin
            top = 5'd1;
        end
        else if (state_count_reg > 6'd32)
        begin
            top = 5'd31;
        end
        else
        begin
            top = 5'(state_count_reg - 6'd1);
        end
    end

    assign cfg.survive     = survive_reg;
    assign cfg.born        = born_reg;
    assign cfg.top         = top;
    assign cfg.von_neumann = neighbor_reg;

    ca3d_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .req_ready  (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    ca3d_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

/* rtl/ca3d_checker.sv */
// Port-level checker for the 3D cellular automaton step unit and its bind statement.
module ca3d_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input ca3d_pkg::rsp_t rsp
);
    import ca3d_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("new word taken while one is still at work");

    a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.action_done != ACT_READ) |->
            (rsp.cell_state == '0) && (rsp.neighbor_total == '0))
        else $error("nonzero fields on a result that is not a read");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.action_done == ACT_READ) |-> rsp.neighbor_total <= 5'd26)
        else $error("neighbor count above 26");

endmodule

bind cellular_automaton_3d_step_unit ca3d_checker u_ca3d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* tb/cellular_automaton_3d_step_unit_test.sv */
// Self-checking testbench for the 3D cellular automaton step unit.
`timescale 1ns / 1ps

module cellular_automaton_3d_step_unit_test;
    import ca3d_pkg::*;

    class grid_scoreboard;
        logic [4:0]    cells [4096];
        logic [4:0]    counts [4096];
        logic [26:0]   survive;
        logic [26:0]   born;
        logic [5:0]    state_count;
        logic          von_neumann;
        rsp_t          expected_words [$];
        int            mismatches;

        function new();
            survive = SURVIVE_RST;
            born = BORN_RST;
            state_count = STATE_COUNT_RST;
            von_neumann = NEIGHBOR_RST;
            mismatches = 0;
            foreach (cells[i])
            begin
                cells[i] = '0;
                counts[i] = '0;
            end
        endfunction

        function int top_state();
            int n;
            n = state_count;
            if (n < 2) n = 2;
            if (n > 32) n = 32;
            return n - 1;
        endfunction

        function void write_reg(logic [1:0] index, logic [26:0] data);
            case (cfg_reg_t'(index))
                REG_SURVIVE:      survive = data;
                REG_BORN:         born = data;
                REG_STATE_COUNT:  state_count = data[5:0];
                REG_NEIGHBORHOOD: von_neumann = data[0];
                default:          von_neumann = von_neumann;
            endcase
        endfunction

        function void count_live(logic [4:0] src [4096]);
            int top;
            int total;
            int offs;
            top = top_state();
            for (int x = 0; x < 16; x++)
                for (int y = 0; y < 16; y++)
                    for (int z = 0; z < 16; z++)
                    begin
                        total = 0;
                        for (int dx = 0; dx < 3; dx++)
                            for (int dy = 0; dy < 3; dy++)
                                for (int dz = 0; dz < 3; dz++)
                                begin
                                    offs = (dx != 1) + (dy != 1) + (dz != 1);
                                    if (offs == 0 || (von_neumann && offs != 1)) continue;
                                    if (src[(((x + 15 + dx) % 16) * 16 + (y + 15 + dy) % 16) * 16
                                            + (z + 15 + dz) % 16] == top)
                                        total++;
                                end
                        counts[(x * 16 + y) * 16 + z] = total[4:0];
                    end
        endfunction

        function void note_input(req_t r);
            int         idx;
            int         top;
            int         c;
            logic [4:0] nxt [4096];
            rsp_t       w;
            idx = (int'(r.cell_x) * 16 + int'(r.cell_y)) * 16 + int'(r.cell_z);
            top = top_state();
            w = '0;
            w.action_done = r.action;
            case (act_t'(r.action))
                ACT_WRITE:   cells[idx] = (r.cell_value > top) ? top[4:0] : r.cell_value;
                ACT_READ:
                begin
                    w.cell_state = cells[idx];
                    w.neighbor_total = counts[idx];
                end
                ACT_RECOUNT: count_live(cells);
                ACT_STEP:
                begin
                    for (int i = 0; i < 4096; i++)
                    begin
                        c = counts[i];
                        if (cells[i] == 0)
                            nxt[i] = born[c] ? top[4:0] : 5'd0;
                        else if (cells[i] == top && survive[c])
                            nxt[i] = cells[i];
                        else
                            nxt[i] = cells[i] - 5'd1;
                    end
                    count_live(nxt);
                    cells = nxt;
                end
                default:     w.action_done = r.action;
            endcase
            expected_words.push_back(w);
        endfunction

        function void check_result(rsp_t got);
            rsp_t w;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", got);
                return;
            end
            w = expected_words.pop_front();
            if (got !== w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected state %0d count %0d action %0d, got %0d %0d %0d",
                             w.cell_state, w.neighbor_total, w.action_done,
                             got.cell_state, got.neighbor_total, got.action_done);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [26:0] cfg_data;

    grid_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    cellular_automaton_3d_step_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready) sb.note_input(req);
        if (rst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
        if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end

    always @(posedge clk)
        if (rst_n) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(cfg_reg_t index, logic [26:0] data);
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic send(act_t a, int x, int y, int z, int v);
        req_t r;
        int   gap;
        r.action = a;
        r.cell_x = x[3:0];
        r.cell_y = y[3:0];
        r.cell_z = z[3:0];
        r.cell_value = v[4:0];
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_words.size() > 0) @(posedge clk);
    endtask

    function automatic int near_coord();
        if ($urandom_range(99) < 70) return ($urandom_range(0, 4) + 14) % 16;
        return $urandom_range(0, 15);
    endfunction

    task automatic random_phase(int items);
        int pick;
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
                send(($urandom_range(1) != 0) ? ACT_STEP : ACT_RECOUNT, 0, 0, 0, 0);
            else
            begin
                pick = $urandom_range(99);
                send((pick < 55) ? ACT_WRITE : ACT_READ, near_coord(), near_coord(),
                     near_coord(), $urandom_range(0, 31));
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send(ACT_READ, 0, 0, 0, 0);
        send(ACT_WRITE, 15, 15, 15, 31);
        send(ACT_WRITE, 0, 0, 0, 1);
        send(ACT_WRITE, 1, 0, 0, 1);
        send(ACT_WRITE, 15, 0, 0, 1);
        send(ACT_WRITE, 0, 1, 0, 0);
        send(ACT_READ, 15, 15, 15, 0);
        send(ACT_RECOUNT, 0, 0, 0, 0);
        send(ACT_READ, 0, 0, 0, 0);
        send(ACT_READ, 0, 15, 0, 0);
        send(ACT_READ, 0, 0, 15, 0);
        drain();

        write_reg(REG_STATE_COUNT, 27'd63);
        write_reg(REG_NEIGHBORHOOD, 27'd0);
        write_reg(REG_SURVIVE, 27'h7FFFFFF);
        write_reg(REG_BORN, 27'd0);
        drain();
        send(ACT_WRITE, 0, 0, 1, 31);
        send(ACT_WRITE, 1, 1, 1, 30);
        send(ACT_READ, 0, 0, 1, 0);
        drain();
        write_reg(REG_STATE_COUNT, 27'd0);
        drain();
        send(ACT_STEP, 0, 0, 0, 0);
        send(ACT_READ, 0, 0, 1, 0);
        send(ACT_READ, 1, 1, 1, 0);
        send(ACT_READ, 0, 0, 0, 0);
        send(ACT_READ, 15, 15, 15, 0);
        send(ACT_WRITE, 2, 2, 2, 1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 45 : (phase == 3) ? 26 : 0;
            recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 26 : 0;
            write_reg(REG_SURVIVE, (phase == 3) ? 27'd0 : 27'($urandom_range(0, 27'h7FFFFFF)));
            write_reg(REG_BORN, (phase == 2) ? 27'h7FFFFFF
                                             : 27'($urandom_range(0, 27'h7FFFFFF)));
            write_reg(REG_STATE_COUNT, (phase == 0) ? 27'd32 : (phase == 1) ? 27'd4
                                       : (phase == 2) ? 27'd1 : 27'($urandom_range(0, 63)));
            write_reg(REG_NEIGHBORHOOD, 27'(phase % 2));
            drain();
            random_phase(20);
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
